// File: sv/sialu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sialu_pkg: shared types and codes
// Opcodes, result kinds and the front-to-back command record.
// ----------------------------------------------------------------------------
package sialu_pkg;

  localparam logic [3:0] OP_ADD = 4'd0;
  localparam logic [3:0] OP_SUB = 4'd1;
  localparam logic [3:0] OP_MUL = 4'd2;
  localparam logic [3:0] OP_DIV = 4'd3;
  localparam logic [3:0] OP_MOD = 4'd4;
  localparam logic [3:0] OP_POW = 4'd5;
  localparam logic [3:0] OP_LT  = 4'd6;
  localparam logic [3:0] OP_GT  = 4'd7;
  localparam logic [3:0] OP_EQ  = 4'd8;

  localparam logic [1:0] KIND_INT  = 2'd0;
  localparam logic [1:0] KIND_BOOL = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_REAL = 2'd3;

  // Work class chosen by the front end.
  localparam logic [1:0] CLS_DONE = 2'd0;  // result already known
  localparam logic [1:0] CLS_MUL  = 2'd1;
  localparam logic [1:0] CLS_DIV  = 2'd2;
  localparam logic [1:0] CLS_POW  = 2'd3;

  localparam int unsigned VW = 64;

  typedef struct packed {
    logic [1:0]    cls;
    logic          want_rem;
    logic [1:0]    kind;
    logic [VW-1:0] a;    // sign-extended operand / base / early result
    logic [VW-1:0] b;
  } cmd_t;

endpackage
`default_nettype wire

// File: sv/signed_integer_alu_with_power.sv
`default_nettype none
// ----------------------------------------------------------------------------
// signed_integer_alu_with_power: signed integer ALU with power
// Add, subtract, multiply, divide, remainder, power and compares at
// DATA_WIDTH bits, sign-extended to 64-bit results.
// ----------------------------------------------------------------------------
//   Channel   Ports                                    Direction
//   input     in_valid/in_ready, in_opcode, operands   into block
//   result    out_valid/out_ready, out_result_*        out of block
//
// Add, subtract, compares and error cases are settled in the front end and go
// from the queue to the output register. Multiply forms three 32x32 partial
// products on one multiplier. Divide and remainder produce one quotient bit
// per cycle. Power squares per exponent bit and multiplies per set bit on the
// shared multiplier. Reset clears the queue and back-end control. A stalled
// result holds in the output register; the one-entry queue takes one more
// beat and then in_ready falls until the result beat is accepted.
// ----------------------------------------------------------------------------
module signed_integer_alu_with_power #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [3:0]  in_opcode,
  input  wire logic [63:0] in_left_operand,
  input  wire logic [63:0] in_right_operand,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_result_value,
  output logic [1:0]       out_result_kind
);
  import sialu_pkg::*;

  cmd_t cmd_c, q_r;
  logic q_v_r, bk_ready;

  sialu_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .in_opcode(in_opcode), .in_left(in_left_operand),
    .in_right(in_right_operand), .cmd(cmd_c));

  // One-entry queue between front and back.
  assign in_ready = !q_v_r || bk_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) q_v_r <= 1'b0;
    else if (in_ready) q_v_r <= in_valid;
    else if (bk_ready) q_v_r <= 1'b0;
    if (in_ready && in_valid) q_r <= cmd_c;
  end

  sialu_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_v_r), .cmd_ready(bk_ready),
    .cmd(q_r), .out_valid(out_valid), .out_ready(out_ready),
    .out_value(out_result_value), .out_kind(out_result_kind));
endmodule
`default_nettype wire

// File: sv/sialu_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sialu_front: operand decode and classification
// Sign-extends operands, settles simple operations at once and marks the
// long ones for the back end.
// ----------------------------------------------------------------------------
module sialu_front #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic [3:0]             in_opcode,
  input  wire logic [63:0]            in_left,
  input  wire logic [63:0]            in_right,
  output sialu_pkg::cmd_t             cmd
);
  import sialu_pkg::*;

  logic [63:0] a, b, s;

  function automatic logic [63:0] sx(input logic [63:0] v);
    logic [63:0] r;
    r = {{(64-DATA_WIDTH){v[DATA_WIDTH-1]}}, v[DATA_WIDTH-1:0]};
    return r;
  endfunction

  always_comb begin
    a = sx(in_left);
    b = sx(in_right);
    s = 64'd0;
    cmd = '0;
    cmd.a = a;
    cmd.b = b;
    cmd.cls = CLS_DONE;
    cmd.kind = KIND_INT;
    case (in_opcode)
      OP_ADD: cmd.a = sx(a + b);
      OP_SUB: cmd.a = sx(a - b);
      OP_MUL: cmd.cls = CLS_MUL;
      OP_DIV, OP_MOD: begin
        if (b == 64'd0) begin
          cmd.kind = KIND_NONE;
          cmd.a = 64'd0;
        end else begin
          cmd.cls = CLS_DIV;
          cmd.want_rem = (in_opcode == OP_MOD);
        end
      end
      OP_POW: begin
        if (b[63]) begin
          cmd.kind = KIND_REAL;
          cmd.a = 64'd0;
        end else begin
          cmd.cls = CLS_POW;
        end
      end
      OP_LT, OP_GT: begin
        s = (in_opcode == OP_LT) ? a - b : b - a;
        cmd.kind = KIND_BOOL;
        cmd.a = {63'd0, (a[63] != b[63]) ?
                 ((in_opcode == OP_LT) ? a[63] : b[63]) : s[63]};
      end
      OP_EQ: begin
        cmd.kind = KIND_BOOL;
        cmd.a = {63'd0, a == b};
      end
      default: begin
        cmd.kind = KIND_NONE;
        cmd.a = 64'd0;
      end
    endcase
  end
endmodule
`default_nettype wire

// File: sv/sialu_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sialu_back: iterative execution unit
// Multiply (via 32x32 partial products), restoring divide and
// square-and-multiply power, one step per cycle, with an output register.
// ----------------------------------------------------------------------------
module sialu_back #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cmd_valid,
  output logic                        cmd_ready,
  input  wire sialu_pkg::cmd_t        cmd,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [63:0]                 out_value,
  output logic [1:0]                  out_kind
);
  import sialu_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;  // 32x32 partial products
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_POWM = 3'd3;  // acc * base
  localparam logic [2:0] S_POWS = 3'd4;  // base * base
  localparam logic [2:0] S_FIN  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [63:0] x_r, x_nxt;      // dividend magnitude / base
  logic [63:0] y_r, y_nxt;      // divisor magnitude / exponent
  logic [63:0] acc_r, acc_nxt;  // product / quotient
  logic [63:0] rem_r, rem_nxt;
  logic [63:0] m_r, m_nxt;      // multiply operand latch
  logic [63:0] mb_r, mb_nxt;
  logic        neg_q_r, neg_q_nxt, neg_r_r, neg_r_nxt, rem_sel_r, rem_sel_nxt;
  logic        pow_r, pow_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] ovl_r, ovl_nxt;
  logic [1:0]  ok_r, ok_nxt;
  logic [31:0] pa, pb;
  logic [63:0] pp;
  logic [64:0] trial;
  logic [63:0] rsh, res_pick;

  function automatic logic [63:0] sx(input logic [63:0] v);
    logic [63:0] r;
    r = {{(64-DATA_WIDTH){v[DATA_WIDTH-1]}}, v[DATA_WIDTH-1:0]};
    return r;
  endfunction

  // One 32x32 partial product per cycle: cnt selects the halves that feed
  // the single multiplier.
  always_comb begin
    pa = cnt_r[0] ? m_r[63:32] : m_r[31:0];
    pb = cnt_r[1] ? mb_r[63:32] : mb_r[31:0];
    pp = {32'd0, pa} * {32'd0, pb};
  end

  assign cmd_ready = (st_r == S_IDLE) && (!ov_r || out_ready);
  assign out_valid = ov_r;
  assign out_value = ovl_r;
  assign out_kind  = ok_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; x_nxt = x_r; y_nxt = y_r;
    acc_nxt = acc_r; rem_nxt = rem_r; m_nxt = m_r; mb_nxt = mb_r;
    neg_q_nxt = neg_q_r; neg_r_nxt = neg_r_r; rem_sel_nxt = rem_sel_r;
    pow_nxt = pow_r; ov_nxt = ov_r; ovl_nxt = ovl_r; ok_nxt = ok_r;
    rem_sel_nxt = rem_sel_r;
    trial = {rem_r, x_r[63]} - {1'b0, y_r};
    rsh = {rem_r[62:0], x_r[63]};
    res_pick = 64'd0;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (cmd_valid && cmd_ready) begin
          case (cmd.cls)
            CLS_DONE: begin
              ov_nxt = 1'b1; ovl_nxt = cmd.a; ok_nxt = cmd.kind;
            end
            CLS_MUL: begin
              m_nxt = cmd.a; mb_nxt = cmd.b; acc_nxt = 64'd0;
              cnt_nxt = 7'd0; pow_nxt = 1'b0; st_nxt = S_MUL;
            end
            CLS_DIV: begin
              x_nxt = cmd.a[63] ? 64'd0 - cmd.a : cmd.a;
              y_nxt = cmd.b[63] ? 64'd0 - cmd.b : cmd.b;
              neg_q_nxt = cmd.a[63] ^ cmd.b[63];
              neg_r_nxt = cmd.a[63];
              rem_sel_nxt = cmd.want_rem;
              rem_nxt = 64'd0; acc_nxt = 64'd0; cnt_nxt = 7'd0;
              st_nxt = S_DIV;
            end
            default: begin
              x_nxt = cmd.a; y_nxt = cmd.b; rem_nxt = 64'd1;
              pow_nxt = 1'b1; st_nxt = S_POWM;
            end
          endcase
        end
      end
      S_MUL: begin
        acc_nxt = (cnt_r[1:0] == 2'd0) ? acc_r + pp : acc_r + {pp[31:0], 32'd0};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r[1:0] == 2'd2) begin
          cnt_nxt = 7'd0;
          if (pow_r) begin
            // rem_r is the power accumulator, x_r the base
            if (y_r == 64'd0) begin
              st_nxt = S_FIN;
            end else if (mb_r == x_r && m_r == x_r && cnt_r[6]) begin
              x_nxt = sx(acc_nxt); y_nxt = {1'b0, y_r[63:1]};
              st_nxt = S_POWM;
            end else begin
              rem_nxt = sx(acc_nxt);
              st_nxt = S_POWS;
            end
          end else begin
            st_nxt = S_FIN;
            rem_nxt = sx(acc_nxt);
          end
        end
      end
      S_POWM: begin
        if (y_r == 64'd0) begin
          st_nxt = S_FIN;
        end else if (y_r[0]) begin
          m_nxt = rem_r; mb_nxt = x_r; acc_nxt = 64'd0; cnt_nxt = 7'd0;
          st_nxt = S_MUL;
        end else begin
          st_nxt = S_POWS;
        end
      end
      S_POWS: begin
        // square the base; cnt bit 6 marks a squaring pass
        m_nxt = x_r; mb_nxt = x_r; acc_nxt = 64'd0; cnt_nxt = 7'd64;
        st_nxt = S_MUL;
      end
      S_DIV: begin
        x_nxt = {x_r[62:0], 1'b0};
        if (!trial[64]) begin
          rem_nxt = trial[63:0]; acc_nxt = {acc_r[62:0], 1'b1};
        end else begin
          rem_nxt = rsh; acc_nxt = {acc_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd63) begin
          st_nxt = S_FIN;
          pow_nxt = 1'b0;
          if (rem_sel_r) acc_nxt = rem_nxt;
          rem_sel_nxt = rem_sel_r;
        end
      end
      S_FIN: begin
        if (!ov_r || out_ready) begin
          if (pow_r) res_pick = rem_r;
          else if (cnt_r == 7'd64) begin
            res_pick = rem_sel_r ? (neg_r_r ? 64'd0 - acc_r : acc_r)
                                 : (neg_q_r ? 64'd0 - acc_r : acc_r);
            res_pick = sx(res_pick);
          end else res_pick = rem_r;
          ov_nxt = 1'b1; ovl_nxt = res_pick; ok_nxt = KIND_INT;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      ov_r <= 1'b0;
      cnt_r <= 7'd0;
      pow_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      cnt_r <= cnt_nxt;
      pow_r <= pow_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; acc_r <= acc_nxt; rem_r <= rem_nxt;
    m_r <= m_nxt; mb_r <= mb_nxt; neg_q_r <= neg_q_nxt; neg_r_r <= neg_r_nxt;
    rem_sel_r <= rem_sel_nxt; ovl_r <= ovl_nxt; ok_r <= ok_nxt;
  end
endmodule
`default_nettype wire
